// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the console writer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/tcw_pkg.sv =====
// types and constants of the text console writer
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int CELL_W = 16;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int IDX_W  = 11;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int SUM_W  = ADDR_W + 1;
  localparam int WIDE_W = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd7;

  typedef enum logic {
    KIND_PUT  = 1'b0,
    KIND_READ = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCROLL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic init_wr;
    logic scroll_wr;
    logic cnt_rst;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic acc_scroll;
    logic cnt_init_last;
    logic cnt_row_last;
    logic out_free;
  } stat_t;

endpackage

// ===== hw/rtl/text_console_writer_unit.sv =====
// a put or read is accepted when idle, its result is registered in the done state
// once the output is free; the input stalls meanwhile, a scrolling put holds the input
// while the single memory write port blanks the new bottom row of 80 cells
// reset: cursor to 0, attribute to 7, then a pass blanks every cell
// with the input stalled; configuration writes are taken during that pass
`include "assert_macros.svh"
module text_console_writer_unit
  import tcw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [ATTR_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              in_kind_i,
  input  logic [CHAR_W-1:0] in_char_code_i,
  input  logic [IDX_W-1:0]  in_cell_index_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [IDX_W-1:0]  out_cursor_pos_o,
  output logic [CELL_W-1:0] out_cell_data_o,
  output logic              out_scrolled_o
);

  logic [ATTR_W-1:0] text_attribute_q;
  cmd_t              cmd;
  stat_t             stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_attribute_q <= ATTR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      text_attribute_q <= cfg_data_i;
    end
  end

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tcw_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_kind_i        (in_kind_i),
    .in_char_code_i   (in_char_code_i),
    .in_cell_index_i  (in_cell_index_i),
    .text_attribute_i (text_attribute_q),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .out_cursor_pos_o (out_cursor_pos_o),
    .out_cell_data_o  (out_cell_data_o),
    .out_scrolled_o   (out_scrolled_o)
  );

  `ASSERT_NEXT(a_busy_after_transfer, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `ASSERT_IMPLIES(a_no_result_overwrite, clk_i, rst_ni, cmd.load_out, stat.out_free)
  `ASSERT_IMPLIES(a_cursor_on_screen, clk_i, rst_ni, out_valid_o, out_cursor_pos_o < IDX_W'(CELL_COUNT))
  `ASSERT_IMPLIES(a_scroll_has_no_data, clk_i, rst_ni, out_valid_o && out_scrolled_o, out_cell_data_o == '0)

endmodule

// ===== hw/rtl/tcw_ctrl.sv =====
// controller state machine of the text console writer
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (stat_i.cnt_init_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = stat_i.acc_scroll ? ST_SCROLL : ST_DONE;
        end
      end
      ST_SCROLL: begin
        if (stat_i.cnt_row_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.init_wr = 1'b1;
        cmd_o.cnt_rst = stat_i.cnt_init_last;
      end
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.accept  = in_valid_i;
        cmd_o.cnt_rst = 1'b1;
      end
      ST_SCROLL: begin
        cmd_o.scroll_wr = 1'b1;
      end
      ST_DONE: begin
        cmd_o.load_out = stat_i.out_free;
      end
      default: begin
        cmd_o.cnt_rst = 1'b1;
      end
    endcase
  end

endmodule

// ===== hw/rtl/tcw_dpath.sv =====
// datapath of the text console writer: cell memory, cursor and result register
module tcw_dpath
  import tcw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_kind_i,
  input  logic [CHAR_W-1:0] in_char_code_i,
  input  logic [IDX_W-1:0]  in_cell_index_i,
  input  logic [ATTR_W-1:0] text_attribute_i,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [IDX_W-1:0]  out_cursor_pos_o,
  output logic [CELL_W-1:0] out_cell_data_o,
  output logic              out_scrolled_o
);

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rd_data_q;

  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ADDR_W-1:0] lin_q, lin_d;
  logic [ADDR_W-1:0] phys_q, phys_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [ADDR_W-1:0] cnt_q;

  logic is_read_q, rd_ok_q, scrolled_q;

  logic              out_valid_q;
  logic [IDX_W-1:0]  out_cursor_q;
  logic [CELL_W-1:0] out_data_q;
  logic              out_scrolled_q;

  logic              is_read, is_newline, col_last, row_last, row_adv, do_scroll;
  logic [SUM_W-1:0]  phys_nx, base_nx;
  logic [WIDE_W-1:0] idx_wide, rd_sum, rd_wrap;
  logic              rd_in_range;
  logic [ADDR_W-1:0] rd_addr;
  logic              we;
  logic [ADDR_W-1:0] wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic [ADDR_W-1:0] cursor_lin;

  assign is_read    = (in_kind_i == KIND_READ);
  assign is_newline = (in_char_code_i == NEWLINE_CODE);
  assign col_last   = (col_q == COL_W'(COLUMNS - 1));
  assign row_last   = (row_q == ROW_W'(ROWS - 1));
  assign row_adv    = is_newline || col_last;
  assign do_scroll  = !is_read && row_adv && row_last;

  // row starts advance by one row, wrapping around the physical store
  always_comb begin
    phys_nx = {1'b0, phys_q} + SUM_W'(COLUMNS);
    if (phys_nx >= SUM_W'(CELL_COUNT)) phys_nx = phys_nx - SUM_W'(CELL_COUNT);
    base_nx = {1'b0, base_q} + SUM_W'(COLUMNS);
    if (base_nx >= SUM_W'(CELL_COUNT)) base_nx = base_nx - SUM_W'(CELL_COUNT);
  end

  // logical cell index to physical address through the rotating base
  always_comb begin
    idx_wide    = WIDE_W'(in_cell_index_i);
    rd_in_range = (idx_wide < WIDE_W'(CELL_COUNT));
    rd_sum      = idx_wide + WIDE_W'(base_q);
    rd_wrap     = (rd_sum >= WIDE_W'(CELL_COUNT)) ? (rd_sum - WIDE_W'(CELL_COUNT)) : rd_sum;
    rd_addr     = rd_wrap[ADDR_W-1:0];
  end

  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    lin_d  = lin_q;
    phys_d = phys_q;
    base_d = base_q;
    if (cmd_i.accept && !is_read) begin
      if (row_adv) begin
        col_d = '0;
        if (row_last) begin
          phys_d = base_q;
          base_d = base_nx[ADDR_W-1:0];
        end else begin
          row_d  = row_q + ROW_W'(1);
          lin_d  = lin_q + ADDR_W'(COLUMNS);
          phys_d = phys_nx[ADDR_W-1:0];
        end
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      lin_q  <= '0;
      phys_q <= '0;
      base_q <= '0;
      cnt_q  <= '0;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      lin_q  <= lin_d;
      phys_q <= phys_d;
      base_q <= base_d;
      if (cmd_i.cnt_rst) begin
        cnt_q <= '0;
      end else if (cmd_i.init_wr || cmd_i.scroll_wr) begin
        cnt_q <= cnt_q + ADDR_W'(1);
      end
    end
  end

  always_comb begin
    we      = 1'b0;
    wr_addr = cnt_q;
    wr_data = BLANK_CELL;
    if (cmd_i.init_wr) begin
      we = 1'b1;
    end else if (cmd_i.scroll_wr) begin
      we      = 1'b1;
      wr_addr = phys_q + cnt_q;
    end else if (cmd_i.accept && !is_read && !is_newline) begin
      we      = 1'b1;
      wr_addr = phys_q + ADDR_W'(col_q);
      wr_data = {text_attribute_i, in_char_code_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.accept && is_read && rd_in_range) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      is_read_q  <= is_read;
      rd_ok_q    <= rd_in_range;
      scrolled_q <= do_scroll;
    end
  end

  assign cursor_lin = lin_q + ADDR_W'(col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_cursor_q   <= IDX_W'(cursor_lin);
      out_data_q     <= (is_read_q && rd_ok_q) ? rd_data_q : '0;
      out_scrolled_q <= scrolled_q;
    end
  end

  assign stat_o.acc_scroll    = do_scroll;
  assign stat_o.cnt_init_last = (cnt_q == ADDR_W'(CELL_COUNT - 1));
  assign stat_o.cnt_row_last  = (cnt_q == ADDR_W'(COLUMNS - 1));
  assign stat_o.out_free      = !out_valid_q || !out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign out_cursor_pos_o = out_cursor_q;
  assign out_cell_data_o  = out_data_q;
  assign out_scrolled_o   = out_scrolled_q;

endmodule

// ===== dv/text_console_writer_unit_tb.sv =====
// testbench for the text console writer: directed and random put and read traffic checked against a screen model
`timescale 1ns / 1ps
module text_console_writer_unit_tb;
  import tcw_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 100;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [IDX_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } console_result_t;

  class console_scoreboard;
    logic [CELL_W-1:0] screen [CELL_COUNT];
    int unsigned       cursor;
    logic [ATTR_W-1:0] attribute;
    console_result_t   pending [$];
    int                errors;

    function new();
      foreach (screen[i]) screen[i] = BLANK_CELL;
      cursor    = 0;
      attribute = ATTR_RESET;
      errors    = 0;
    endfunction

    function void note_input(kind_e kind, logic [CHAR_W-1:0] code, logic [IDX_W-1:0] idx);
      console_result_t r;
      int unsigned     i;
      r = '0;
      if (kind == KIND_READ) begin
        if (idx < CELL_COUNT) r.cell_data = screen[idx];
      end else begin
        if (code == NEWLINE_CODE) begin
          cursor = (cursor / COLUMNS + 1) * COLUMNS;
        end else begin
          screen[cursor] = {attribute, code};
          cursor++;
        end
        if (cursor >= CELL_COUNT) begin
          for (i = 0; i < CELL_COUNT - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
          for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) screen[i] = BLANK_CELL;
          cursor -= COLUMNS;
          r.scrolled = 1'b1;
        end
      end
      r.cursor_pos = IDX_W'(cursor);
      pending.push_back(r);
    endfunction

    function void check_result(console_result_t actual);
      console_result_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected transfer: cursor %0d data %h scrolled %b",
                   actual.cursor_pos, actual.cell_data, actual.scrolled);
        return;
      end
      exp = pending.pop_front();
      if (actual.cursor_pos !== exp.cursor_pos || actual.cell_data !== exp.cell_data ||
          actual.scrolled !== exp.scrolled) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("mismatch: cursor %0d/%0d data %h/%h scrolled %b/%b (expected/actual)",
                   exp.cursor_pos, actual.cursor_pos, exp.cell_data, actual.cell_data,
                   exp.scrolled, actual.scrolled);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              cfg_valid   = 1'b0;
  logic              cfg_ready;
  logic [ATTR_W-1:0] cfg_data    = '0;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  kind_e             in_kind     = KIND_PUT;
  logic [CHAR_W-1:0] in_char     = '0;
  logic [IDX_W-1:0]  in_index    = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  logic [IDX_W-1:0]  out_cursor;
  logic [CELL_W-1:0] out_data;
  logic              out_scrolled;

  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                quiet_cycles  = 0;
  console_scoreboard sb = new();

  text_console_writer_unit dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .in_kind_i        (in_kind),
    .in_char_code_i   (in_char),
    .in_cell_index_i  (in_index),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .out_cursor_pos_o (out_cursor),
    .out_cell_data_o  (out_data),
    .out_scrolled_o   (out_scrolled)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{cursor_pos: out_cursor, cell_data: out_data, scrolled: out_scrolled});
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_item(input kind_e kind, input logic [CHAR_W-1:0] code,
                           input logic [IDX_W-1:0] idx);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_kind  = kind;
    in_char  = code;
    in_index = idx;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_input(kind, code, idx);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.attribute = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_random_traffic(input int count);
    int               k;
    int               sel;
    logic [IDX_W-1:0] idx;
    for (k = 0; k < count; k++) begin
      if (k == count / 2) drain_results();
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        if ($urandom_range(0, 9) == 0) idx = IDX_W'($urandom_range(CELL_COUNT, 2047));
        else idx = IDX_W'($urandom_range(0, CELL_COUNT - 1));
        send_item(KIND_READ, CHAR_W'($urandom), idx);
      end else if (sel < 44) begin
        send_item(KIND_PUT, NEWLINE_CODE, IDX_W'($urandom));
      end else begin
        send_item(KIND_PUT, CHAR_W'($urandom), IDX_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_attribute(8'h1E);
    send_item(KIND_PUT, 8'h00, '0);
    send_item(KIND_PUT, 8'hFF, '1);
    send_item(KIND_PUT, 8'h41, '0);
    send_item(KIND_PUT, NEWLINE_CODE, '0);
    send_item(KIND_READ, 8'h00, 11'd0);
    send_item(KIND_READ, 8'hFF, 11'd1);
    send_item(KIND_READ, 8'h00, 11'd2);
    send_item(KIND_READ, 8'h00, 11'd3);
    send_item(KIND_READ, 8'h00, IDX_W'(CELL_COUNT - 1));
    send_item(KIND_READ, 8'h00, IDX_W'(CELL_COUNT));
    send_item(KIND_READ, 8'h00, 11'h7FF);
    // walk down to the last row, then newline there to force a scroll
    while (sb.cursor < (ROWS - 1) * COLUMNS) send_item(KIND_PUT, NEWLINE_CODE, '1);
    send_item(KIND_PUT, NEWLINE_CODE, '0);
    send_item(KIND_READ, 8'h00, IDX_W'((ROWS - 1) * COLUMNS));
    send_item(KIND_READ, 8'h00, 11'd0);
    drain_results();

    write_attribute(8'hFF);
    send_idle_pct = 32;
    recv_idle_pct = 49;
    run_random_traffic(370);
    drain_results();

    write_attribute(8'h00);
    send_idle_pct = 49;
    recv_idle_pct = 32;
    run_random_traffic(370);
    drain_results();

    write_attribute(ATTR_W'($urandom_range(1, 254)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_traffic(360);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== text_console_writer_unit.f =====
+incdir+hw/rtl
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/tcw_dpath.sv
hw/rtl/text_console_writer_unit.sv
dv/text_console_writer_unit_tb.sv
